@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds in a cycle, consequent holds in the same cycle.
`define SHA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sha256 check failed");

// Antecedent holds in a cycle, consequent holds in the next cycle.
`define SHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sha256 check failed");

`endif

@@ hw/rtl/sha256_pkg.sv @@
// Types, operation codes, round constants and round functions of the SHA-256 hasher.
// Depends on nothing; used by the top level.
package sha256_pkg;

   typedef enum logic [1:0] {
      OP_ABSORB     = 2'd0,
      OP_ABSORB_FIN = 2'd1,
      OP_FINISH     = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } state_type;

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_OFFSET = 6'd56;
   localparam logic [5:0] LAST_SLOT = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_WORD = 3'd7;

   localparam logic [31:0] INIT_H [0:7] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [31:0] ROUND_K [0:63] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'd0, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

endpackage

@@ hw/rtl/sha256_byte_stream_hasher_top.sv @@
// SHA-256 hasher over a byte stream: block window, one-round-per-cycle compression, digest output.
// Depends on sha256_pkg.
//
//   channel | dir | tdata                          | tuser     | tlast
//   req     | in  | data_byte[7:0]                 | operation | -
//   rsp     | out | digest_word[31:0], word_index  | -         | last_word
//
// An absorbed byte enters the block window; a byte that fills a 64-byte block then runs
// 64 rounds through the single round unit, then the chaining add.
// A finish pushes padding bytes one per cycle except while a full block is compressed, compresses
// one or two blocks, then shows eight digest items, one per cycle unless rsp_tready stalls them.
// req_tready is high only while the sequencer is idle. Reset is synchronous and restores
// the initial hash values, a zero bit count and an empty block.
module sha256_byte_stream_hasher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
   output logic        rsp_tlast    // last_word
);

   sha256_pkg::state_type state_ff, state_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [31:0] chain_ff [0:7];
   logic [31:0] chain_in [0:7];
   logic [31:0] v_ff [0:7];
   logic [31:0] v_in [0:7];
   logic [31:0] w_ff [0:15];
   logic [31:0] w_in [0:15];
   logic [5:0]  rnd_ff, rnd_in;
   logic        fin_ff, fin_in;
   logic        mark_ff, mark_in;
   logic        lenph_ff, lenph_in;
   logic [2:0]  oidx_ff, oidx_in;

   logic        push_en;
   logic [7:0]  push_byte;
   logic [7:0]  len_byte;
   logic        use_len;
   logic [31:0] t1, t2, w_new;
   logic [63:0] len_shift;
   logic        req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Length bytes go out most significant first while the fill runs 56..63.
   assign len_shift = bits_ff >> {~fill_ff[2:0], 3'b000};
   assign len_byte = len_shift[7:0];
   assign use_len = lenph_ff || (!mark_ff && fill_ff == sha256_pkg::LEN_OFFSET);

   assign t1 = v_ff[7] + sha256_pkg::big_sigma1(v_ff[4])
             + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
             + sha256_pkg::ROUND_K[rnd_ff] + w_ff[0];
   assign t2 = sha256_pkg::big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   assign w_new = w_ff[0] + sha256_pkg::small_sigma0(w_ff[1]) + w_ff[9]
                + sha256_pkg::small_sigma1(w_ff[14]);

   assign rsp_tdata = {5'd0, oidx_ff, chain_ff[oidx_ff]};
   assign rsp_tlast = (oidx_ff == sha256_pkg::LAST_WORD);

   always_comb begin
      state_in = state_ff;
      fill_in = fill_ff;
      bits_in = bits_ff;
      chain_in = chain_ff;
      v_in = v_ff;
      w_in = w_ff;
      rnd_in = rnd_ff;
      fin_in = fin_ff;
      mark_in = mark_ff;
      lenph_in = lenph_ff;
      oidx_in = oidx_ff;
      push_en = 1'b0;
      push_byte = req_tdata;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;

      unique case (state_ff)
         sha256_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_acc) begin
               unique case (req_tuser)
                  sha256_pkg::OP_ABSORB, sha256_pkg::OP_ABSORB_FIN: begin
                     push_en = 1'b1;
                     bits_in = bits_ff + 64'd8;
                     fin_in = (req_tuser == sha256_pkg::OP_ABSORB_FIN);
                     mark_in = 1'b1;
                     lenph_in = 1'b0;
                     state_in = (req_tuser == sha256_pkg::OP_ABSORB_FIN) ?
                                sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
                  end
                  sha256_pkg::OP_FINISH: begin
                     fin_in = 1'b1;
                     mark_in = 1'b1;
                     lenph_in = 1'b0;
                     state_in = sha256_pkg::ST_PAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sha256_pkg::ST_PAD: begin
            push_en = 1'b1;
            push_byte = mark_ff ? sha256_pkg::PAD_MARK : (use_len ? len_byte : 8'd0);
            mark_in = 1'b0;
            lenph_in = !mark_ff && use_len;
         end
         sha256_pkg::ST_ROUND: begin
            for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
            w_in[15] = w_new;
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == sha256_pkg::LAST_ROUND) state_in = sha256_pkg::ST_ADD;
         end
         sha256_pkg::ST_ADD: begin
            for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + v_ff[i];
            // A block compressed after the length bytes is the final one.
            if (!fin_ff) state_in = sha256_pkg::ST_IDLE;
            else if (lenph_ff) state_in = sha256_pkg::ST_OUT;
            else state_in = sha256_pkg::ST_PAD;
         end
         sha256_pkg::ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_acc) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == sha256_pkg::LAST_WORD) begin
                  chain_in = sha256_pkg::INIT_H;
                  fill_in = 6'd0;
                  bits_in = 64'd0;
                  fin_in = 1'b0;
                  lenph_in = 1'b0;
                  state_in = sha256_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha256_pkg::ST_IDLE;
      endcase

      // The block window shifts one byte in; a full window starts the rounds.
      if (push_en) begin
         for (int i = 0; i < 15; i++) w_in[i] = {w_ff[i][23:0], w_ff[i + 1][31:24]};
         w_in[15] = {w_ff[15][23:0], push_byte};
         fill_in = fill_ff + 6'd1;
         if (fill_ff == sha256_pkg::LAST_SLOT) begin
            v_in = chain_ff;
            rnd_in = 6'd0;
            state_in = sha256_pkg::ST_ROUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::ST_IDLE;
         fill_ff <= 6'd0;
         bits_ff <= 64'd0;
         chain_ff <= sha256_pkg::INIT_H;
         rnd_ff <= 6'd0;
         fin_ff <= 1'b0;
         mark_ff <= 1'b0;
         lenph_ff <= 1'b0;
         oidx_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         chain_ff <= chain_in;
         rnd_ff <= rnd_in;
         fin_ff <= fin_in;
         mark_ff <= mark_in;
         lenph_ff <= lenph_in;
         oidx_ff <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      w_ff <= w_in;
   end

endmodule

@@ hw/rtl/sha256_checker.sv @@
// Port-level checks of the SHA-256 hasher, bound to the top level.
// Depends on assert_macros.svh and sha256_byte_stream_hasher_top.
`include "assert_macros.svh"

module sha256_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);

   `SHA_ASSERT_SAME(a_last_on_seventh, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tdata[34:32] == 3'd7))
   `SHA_ASSERT_SAME(a_no_req_while_rsp, clock, reset, rsp_tvalid, !req_tready)
   `SHA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `SHA_ASSERT_NEXT(a_index_steps, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1)

endmodule

bind sha256_byte_stream_hasher_top sha256_checker u_sha256_checker (.*);
